[rtl/core/hm3_pkg.sv]
// shared constants, types and hash helper for the 3d hash map
// no dependencies

package hm3_pkg;

  // table geometry
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);

  // field widths
  localparam int unsigned COORD_W = 32;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned OCC_W   = 11;
  localparam int unsigned KEY_W   = 3 * COORD_W;

  localparam logic [OCC_W-1:0]   COUNT_MAX = {OCC_W{1'b1}};
  localparam logic [COORD_W-1:0] HASH_MULT = 32'h045d_9f3b;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 2'd2;

  // operation codes
  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_SET = 1'b1;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MIX1,
    ST_MIX2,
    ST_MIX3,
    ST_ISSUE,
    ST_CHECK,
    ST_FINISH
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic mix1;
    logic mix2;
    logic mix3;
    logic advance;
    logic finish;
    logic clear_wr;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic slot_empty;
    logic slot_match;
    logic last_probe;
    logic clear_last;
    logic out_stall;
  } status_t;

  // arithmetic shift right by 16 folded back in
  function automatic logic [COORD_W-1:0] asr16_xor(input logic [COORD_W-1:0] v);
    return {{16{v[COORD_W-1]}}, v[COORD_W-1:16]} ^ v;
  endfunction

endpackage

[rtl/core/hm3_if.sv]
// valid/ready channel interfaces for requests and responses
// depends on hm3_pkg

interface hm3_req_if;
  import hm3_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic signed [COORD_W-1:0] key_x;
  logic signed [COORD_W-1:0] key_y;
  logic signed [COORD_W-1:0] key_z;
  logic        [VAL_W-1:0]   new_value;

  modport source (output valid, kind, key_x, key_y, key_z, new_value, input ready);
  modport sink   (input valid, kind, key_x, key_y, key_z, new_value, output ready);
endinterface

interface hm3_rsp_if;
  import hm3_pkg::*;

  logic               valid;
  logic               ready;
  logic [VAL_W-1:0]   read_value;
  logic               changed;
  logic               table_full;
  logic [OCC_W-1:0]   occupancy;

  modport source (output valid, read_value, changed, table_full, occupancy, input ready);
  modport sink   (input valid, read_value, changed, table_full, occupancy, output ready);
endinterface

[rtl/core/hm3_ctrl.sv]
// controller for the 3d hash map: clear pass, hash sequence, probe loop
// depends on hm3_pkg

module hm3_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  hm3_pkg::status_t status,
  output hm3_pkg::cmd_t    cmd
);
  import hm3_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (status.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_MIX1;
      end
      ST_MIX1:  state_nxt = ST_MIX2;
      ST_MIX2:  state_nxt = ST_MIX3;
      ST_MIX3:  state_nxt = ST_ISSUE;
      ST_ISSUE: state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (status.slot_empty || status.slot_match || status.last_probe) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!status.out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_CLEAR: cmd.clear_wr = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_MIX1:  cmd.mix1 = 1'b1;
      ST_MIX2:  cmd.mix2 = 1'b1;
      ST_MIX3:  cmd.mix3 = 1'b1;
      ST_ISSUE: cmd = '0;
      ST_CHECK: begin
        cmd.advance = !(status.slot_empty || status.slot_match || status.last_probe);
      end
      ST_FINISH: cmd.finish = !status.out_stall;
      default: cmd = '0;
    endcase
  end

endmodule

[rtl/core/hm3_dp.sv]
// datapath for the 3d hash map: offsets, hash lanes, slot memories, result register
// depends on hm3_pkg

module hm3_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_we,
  input  logic [hm3_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hm3_pkg::COORD_W-1:0]        cfg_data,
  // request payload
  input  logic                               in_kind,
  input  logic [hm3_pkg::COORD_W-1:0]        in_key_x,
  input  logic [hm3_pkg::COORD_W-1:0]        in_key_y,
  input  logic [hm3_pkg::COORD_W-1:0]        in_key_z,
  input  logic [hm3_pkg::VAL_W-1:0]          in_new_value,
  // response
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [hm3_pkg::VAL_W-1:0]          out_read_value,
  output logic                               out_changed,
  output logic                               out_table_full,
  output logic [hm3_pkg::OCC_W-1:0]          out_occupancy,
  // control
  input  hm3_pkg::cmd_t                      cmd,
  output hm3_pkg::status_t                   status
);
  import hm3_pkg::*;

  logic [COORD_W-1:0] offset_x_r, offset_y_r, offset_z_r;

  logic [2:0][COORD_W-1:0] key_r;
  logic [2:0][COORD_W-1:0] rel_r;
  logic [2:0][COORD_W-1:0] mix_r;
  logic                    kind_r;
  logic [VAL_W-1:0]        wval_r;

  logic [ADDR_W-1:0] probe_addr_r;
  logic [ADDR_W-1:0] probe_addr_nxt;
  logic [ADDR_W-1:0] probe_cnt_r;
  logic [ADDR_W-1:0] rd_addr;
  logic [COORD_W-1:0] fold;

  logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
  logic [VAL_W-1:0] val_mem [TABLE_DEPTH];
  logic [KEY_W-1:0] key_rd_r;
  logic [VAL_W-1:0] val_rd_r;

  logic             slot_empty;
  logic             slot_match;
  logic             full;
  logic             key_we;
  logic             val_we;
  logic [VAL_W-1:0] val_wdata;

  logic [OCC_W-1:0] entry_count_r;
  logic [OCC_W-1:0] entry_count_nxt;
  logic             out_valid_r;
  logic [VAL_W-1:0] out_read_value_r;
  logic             out_changed_r;
  logic             out_table_full_r;
  logic [OCC_W-1:0] out_occupancy_r;

  // offset registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_x_r <= '0;
      offset_y_r <= '0;
      offset_z_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OFFSET_X: offset_x_r <= cfg_data;
        REG_OFFSET_Y: offset_y_r <= cfg_data;
        REG_OFFSET_Z: offset_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // request capture and relative key
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= in_kind;
      wval_r   <= in_new_value;
      key_r[0] <= in_key_x;
      key_r[1] <= in_key_y;
      key_r[2] <= in_key_z;
      rel_r[0] <= in_key_x - offset_x_r;
      rel_r[1] <= in_key_y - offset_y_r;
      rel_r[2] <= in_key_z - offset_z_r;
    end
  end

  // hash lanes: one multiply round per cycle per coordinate
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (cmd.mix1) begin
        mix_r[i] <= asr16_xor(key_r[i]) * HASH_MULT;
      end else if (cmd.mix2) begin
        mix_r[i] <= asr16_xor(mix_r[i]) * HASH_MULT;
      end
    end
  end

  assign fold = asr16_xor(mix_r[0]) ^ asr16_xor(mix_r[1]) ^ asr16_xor(mix_r[2]);

  // probe address, doubles as the clear sweep pointer
  always_comb begin
    probe_addr_nxt = probe_addr_r;
    if (cmd.mix3) begin
      probe_addr_nxt = fold[ADDR_W-1:0];
    end else if (cmd.advance || cmd.clear_wr) begin
      probe_addr_nxt = probe_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_addr_r <= '0;
    end else begin
      probe_addr_r <= probe_addr_nxt;
    end
  end

  // probe counter for the one-pass bound
  always_ff @(posedge clk) begin
    if (cmd.mix3) begin
      probe_cnt_r <= '0;
    end else if (cmd.advance) begin
      probe_cnt_r <= probe_cnt_r + 1'b1;
    end
  end

  // next slot is read while the current one is checked
  assign rd_addr = cmd.advance ? probe_addr_nxt : probe_addr_r;

  // slot compare
  assign slot_empty = (val_rd_r == '0);
  assign slot_match = !slot_empty && (key_rd_r == {rel_r[0], rel_r[1], rel_r[2]});
  assign full       = !slot_empty && !slot_match;

  // write decisions for the clear sweep and at the end of an operation
  always_comb begin
    key_we    = 1'b0;
    val_we    = 1'b0;
    val_wdata = wval_r;
    if (cmd.clear_wr) begin
      val_we    = 1'b1;
      val_wdata = '0;
    end else if (cmd.finish && kind_r == KIND_SET) begin
      if (slot_match) begin
        val_we = (val_rd_r != wval_r);
      end else if (slot_empty && wval_r != '0) begin
        val_we = 1'b1;
        key_we = 1'b1;
      end
    end
  end

  // slot memories
  always_ff @(posedge clk) begin
    key_rd_r <= key_mem[rd_addr];
    if (key_we) begin
      key_mem[probe_addr_r] <= {rel_r[0], rel_r[1], rel_r[2]};
    end
  end

  always_ff @(posedge clk) begin
    val_rd_r <= val_mem[rd_addr];
    if (val_we) begin
      val_mem[probe_addr_r] <= val_wdata;
    end
  end

  // entry count, saturating
  always_comb begin
    entry_count_nxt = entry_count_r;
    if (key_we && entry_count_r != COUNT_MAX) begin
      entry_count_nxt = entry_count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else begin
      entry_count_r <= entry_count_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_read_value_r <= (kind_r == KIND_GET && !full) ? val_rd_r : '0;
      out_changed_r    <= val_we;
      out_table_full_r <= full;
      out_occupancy_r  <= entry_count_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_changed    = out_changed_r;
  assign out_table_full = out_table_full_r;
  assign out_occupancy  = out_occupancy_r;

  // status back to the controller
  assign status.slot_empty = slot_empty;
  assign status.slot_match = slot_match;
  assign status.last_probe = (probe_cnt_r == ADDR_W'(TABLE_DEPTH - 1));
  assign status.clear_last = (probe_addr_r == ADDR_W'(TABLE_DEPTH - 1));
  assign status.out_stall  = out_valid_r && !out_ready;

endmodule

[rtl/core/hash_map_3d_linear_probe_top.sv]
// sequence: MIX1, MIX2 and MIX3 hash the key, ISSUE reads the first slot, CHECK probes 1..1024 slots,
//   then FINISH registers the result; a new request is taken only back in IDLE after FINISH; the probe loop
//   checks one slot per cycle through the single read port of the slot memory
// reset: a sweep through all slots clears the value store, requests are held off until it ends;
//   offsets and entry count reset to zero, stored keys are left as they are
module hash_map_3d_linear_probe_top (
  input  logic                          clk,
  input  logic                          rst_n,
  hm3_req_if.sink                       in_chan,
  hm3_rsp_if.source                     out_chan,
  input  logic                          cfg_we,
  input  logic [hm3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hm3_pkg::COORD_W-1:0]   cfg_data
);
  import hm3_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  // sequencing
  hm3_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  assign in_chan.ready = in_ready;

  // hashing, storage and result
  hm3_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_kind        (in_chan.kind),
    .in_key_x       (in_chan.key_x),
    .in_key_y       (in_chan.key_y),
    .in_key_z       (in_chan.key_z),
    .in_new_value   (in_chan.new_value),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .out_read_value (out_chan.read_value),
    .out_changed    (out_chan.changed),
    .out_table_full (out_chan.table_full),
    .out_occupancy  (out_chan.occupancy),
    .cmd            (cmd),
    .status         (status)
  );

`ifndef SYNTH
  // a finished result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_chan.valid || out_chan.ready))
    else $error("result overwritten while stalled");

  // no request taken during the clear sweep
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_wr |-> !in_chan.ready)
    else $error("request accepted during clear sweep");

  // a full pass never changes the table
  a_full_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> !(out_chan.changed && out_chan.table_full))
    else $error("change reported on full table");

  // a new result follows a finishing cycle
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(cmd.finish))
    else $error("result valid without finish");
`endif

endmodule
